@@ rtl/ectc_pkg.sv @@
// shared types, constants and helpers for the epoch seconds to calendar converter
// no dependencies; imported by ectc_ctrl, ectc_dp and the top level
package ectc_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int DIVR_W     = 17;
    // seconds left after the month loop stay below 31 days
    localparam int REM_W      = 22;
    localparam int YSECS_W    = 25;
    localparam int YEAR_W     = 12;
    localparam int RCP_W      = 15;
    localparam int QUO_W      = 6;

    localparam logic [DIVR_W-1:0]  SECS_PER_DAY   = DIVR_W'(86400);
    localparam logic [DIVR_W-1:0]  SECS_PER_HOUR  = DIVR_W'(3600);
    localparam logic [DIVR_W-1:0]  SECS_PER_MIN   = DIVR_W'(60);
    localparam logic [YSECS_W-1:0] YEAR_SECS      = YSECS_W'(365 * 86400);
    localparam logic [YSECS_W-1:0] LEAP_YEAR_SECS = YSECS_W'(366 * 86400);

    // q = ((x >> pre) * rcp) >> post, exact over the range each stage sees
    // day: pre 7, divide by 675; hour: pre 4, by 225; minute: pre 2, by 15
    localparam logic [RCP_W-1:0] RCP_DAY   = RCP_W'(24856);
    localparam logic [RCP_W-1:0] RCP_HOUR  = RCP_W'(4661);
    localparam logic [RCP_W-1:0] RCP_MIN   = RCP_W'(1093);
    localparam int               DAY_POST  = 24;
    localparam int               HOUR_POST = 20;
    localparam int               MIN_POST  = 14;

    localparam logic [YEAR_W-1:0] FIRST_YEAR    = YEAR_W'(1970);
    localparam logic [6:0]        FIRST_MOD100  = 7'd70;
    localparam logic [8:0]        FIRST_MOD400  = 9'd370;
    localparam logic [6:0]        MOD100_LAST   = 7'd99;
    localparam logic [8:0]        MOD400_LAST   = 9'd399;
    localparam logic [3:0]        MON_LAST      = 4'd11;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     year_step;
        logic     mon_step;
        logic     quo_step;
        logic     rem_step;
        t_div_sel div_sel;
        logic     out_load;
    } t_ectc_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_ectc_sts;

    // month length, index 0 is january
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/ectc_ctrl.sv @@
// sequencer for the epoch converter: runs the year and month loops and the divide stages
// depends on ectc_pkg; drives ectc_dp through t_ectc_cmd, reads t_ectc_sts
module ectc_ctrl
    import ectc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_ectc_sts i_sts,
    output t_ectc_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DAY_Q,
        S_DAY_R,
        S_HOUR_Q,
        S_HOUR_R,
        S_MIN_Q,
        S_MIN_R,
        S_DONE
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;
    logic             accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_DAY;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_YEAR;
                end
            end
            S_YEAR: begin
                if (i_sts.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_sts.month_done) begin
                    n_state = S_DAY_Q;
                end else begin
                    o_cmd.mon_step = 1'b1;
                end
            end
            S_DAY_Q: begin
                o_cmd.quo_step = 1'b1;
                o_cmd.div_sel  = DIV_DAY;
                n_state        = S_DAY_R;
            end
            S_DAY_R: begin
                o_cmd.rem_step = 1'b1;
                o_cmd.div_sel  = DIV_DAY;
                n_state        = S_HOUR_Q;
            end
            S_HOUR_Q: begin
                o_cmd.quo_step = 1'b1;
                o_cmd.div_sel  = DIV_HOUR;
                n_state        = S_HOUR_R;
            end
            S_HOUR_R: begin
                o_cmd.rem_step = 1'b1;
                o_cmd.div_sel  = DIV_HOUR;
                n_state        = S_MIN_Q;
            end
            S_MIN_Q: begin
                o_cmd.quo_step = 1'b1;
                o_cmd.div_sel  = DIV_MIN;
                n_state        = S_MIN_R;
            end
            S_MIN_R: begin
                o_cmd.rem_step = 1'b1;
                o_cmd.div_sel  = DIV_MIN;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an unread result");

    a_accept_starts_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_YEAR))
        else $error("accepted request did not start the year loop");
`endif

endmodule

@@ rtl/ectc_dp.sv @@
// datapath: year and month subtract loops, reciprocal divide stages, output register
// depends on ectc_pkg; controlled by ectc_ctrl through t_ectc_cmd
module ectc_dp
    import ectc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ectc_cmd         i_cmd,
    input  logic [31:0]       i_epoch_seconds,
    output t_ectc_sts         o_sts,
    output logic [YEAR_W-1:0] o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day,
    output logic [4:0]        o_hour,
    output logic [5:0]        o_minute,
    output logic [5:0]        o_second
);

    logic [TIME_WIDTH-1:0]   r_secs;
    logic [QUO_W-1:0]        r_quo;
    logic [4:0]              r_day;
    logic [4:0]              r_hour;
    logic [5:0]              r_minute;
    logic [YEAR_W-1:0]       r_year;
    logic [6:0]              r_mod100;
    logic [8:0]              r_mod400;
    logic [3:0]              r_mon;

    logic [REM_W-1:0]        rem_sec;
    logic [DIVR_W-1:0]       divisor;
    logic [RCP_W-1:0]        rcp_x;
    logic [RCP_W-1:0]        rcp_m;
    logic [2*RCP_W-1:0]      rcp_prod;
    logic [QUO_W-1:0]        quo;
    logic [DIVR_W+QUO_W-1:0] quo_prod;
    logic                    leap;
    logic [YSECS_W-1:0]      ysecs;
    logic [4:0]              mlen;
    logic [REM_W-1:0]        msecs;

    assign rem_sec = r_secs[REM_W-1:0];

    // each stage sees less than a month, a day and an hour of seconds in turn
    always_comb begin
        case (i_cmd.div_sel)
            DIV_DAY: begin
                divisor = SECS_PER_DAY;
                rcp_x   = rem_sec[REM_W-1:7];
                rcp_m   = RCP_DAY;
            end
            DIV_HOUR: begin
                divisor = SECS_PER_HOUR;
                rcp_x   = RCP_W'(rem_sec[16:4]);
                rcp_m   = RCP_HOUR;
            end
            DIV_MIN: begin
                divisor = SECS_PER_MIN;
                rcp_x   = RCP_W'(rem_sec[11:2]);
                rcp_m   = RCP_MIN;
            end
            default: begin
                divisor = SECS_PER_DAY;
                rcp_x   = rem_sec[REM_W-1:7];
                rcp_m   = RCP_DAY;
            end
        endcase
    end

    assign rcp_prod = rcp_x * rcp_m;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_DAY:  quo = rcp_prod[DAY_POST +: QUO_W];
            DIV_HOUR: quo = rcp_prod[HOUR_POST +: QUO_W];
            DIV_MIN:  quo = rcp_prod[MIN_POST +: QUO_W];
            default:  quo = rcp_prod[DAY_POST +: QUO_W];
        endcase
    end

    assign quo_prod = r_quo * divisor;

    assign leap  = ((r_year[1:0] == 2'b00) && (r_mod100 != '0)) || (r_mod400 == '0);
    assign ysecs = leap ? LEAP_YEAR_SECS : YEAR_SECS;
    assign mlen  = month_len(r_mon, leap);
    assign msecs = mlen * SECS_PER_DAY;

    assign o_sts.year_done  = (r_secs < TIME_WIDTH'(ysecs));
    assign o_sts.month_done = (r_mon == MON_LAST) || (r_secs < TIME_WIDTH'(msecs));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_secs   <= TIME_WIDTH'(i_epoch_seconds);
            r_year   <= FIRST_YEAR;
            r_mod100 <= FIRST_MOD100;
            r_mod400 <= FIRST_MOD400;
            r_mon    <= '0;
        end
        if (i_cmd.year_step) begin
            r_secs   <= r_secs - TIME_WIDTH'(ysecs);
            r_year   <= r_year + 1'b1;
            r_mod100 <= (r_mod100 == MOD100_LAST) ? '0 : r_mod100 + 1'b1;
            r_mod400 <= (r_mod400 == MOD400_LAST) ? '0 : r_mod400 + 1'b1;
        end
        if (i_cmd.mon_step) begin
            r_secs <= r_secs - TIME_WIDTH'(msecs);
            r_mon  <= r_mon + 1'b1;
        end
        if (i_cmd.quo_step) begin
            r_quo <= quo;
        end
        if (i_cmd.rem_step) begin
            r_secs <= r_secs - TIME_WIDTH'(quo_prod);
            case (i_cmd.div_sel)
                DIV_DAY:  r_day    <= r_quo[4:0];
                DIV_HOUR: r_hour   <= r_quo[4:0];
                DIV_MIN:  r_minute <= r_quo;
                default:  r_day    <= r_quo[4:0];
            endcase
        end
        if (i_cmd.out_load) begin
            o_year   <= r_year;
            o_month  <= r_mon + 1'b1;
            o_day    <= r_day + 1'b1;
            o_hour   <= r_hour;
            o_minute <= r_minute;
            o_second <= r_secs[5:0];
        end
    end

`ifndef SYNTH
    a_month_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mon_step |-> (r_mon != MON_LAST))
        else $error("month stepped past december");

    a_quotient_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rem_step |-> (TIME_WIDTH'(quo_prod) <= r_secs &&
                            (r_secs - TIME_WIDTH'(quo_prod)) < TIME_WIDTH'(divisor)))
        else $error("reciprocal quotient off by one");
`endif

endmodule

@@ rtl/epoch_seconds_to_calendar_core.sv @@
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_epoch_seconds
// out     | output    | o_out_valid / i_out_ready  | o_year o_month o_day o_hour o_minute o_second
//
// a request steps once per whole year since 1970 (up to 136), then once per month index
// (0 to 11), before the day, hour and minute stages and the load of the result register
// day, hour and minute each run a reciprocal multiply, then a subtract
// one request is in work at a time; the next is taken once the result is loaded
// reset is synchronous and active low; it clears the sequencer and the output valid
// a stalled result holds only the final load, the next request is still accepted
module epoch_seconds_to_calendar_core
    import ectc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [31:0]       i_epoch_seconds,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [YEAR_W-1:0] o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day,
    output logic [4:0]        o_hour,
    output logic [5:0]        o_minute,
    output logic [5:0]        o_second
);

    t_ectc_cmd cmd;
    t_ectc_sts sts;

    ectc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ectc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .o_sts           (sts),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for epoch_seconds_to_calendar_core: a calendar predictor and date queue
// live in a small scoreboard class; depends on ectc_pkg and the core rtl only

typedef struct packed {
    logic [ectc_pkg::YEAR_W-1:0] year;
    logic [3:0]                  month;
    logic [4:0]                  day;
    logic [4:0]                  hour;
    logic [5:0]                  minute;
    logic [5:0]                  second;
} t_cal_date;

typedef struct packed {
    logic [31:0] secs;
    t_cal_date   date;
} t_pending_date;

localparam longint unsigned SECS_IN_DAY  = 86400;
localparam longint unsigned SECS_IN_HOUR = 3600;
localparam longint unsigned SECS_IN_MIN  = 60;
localparam int unsigned     EPOCH_YEAR   = 1970;

function automatic bit leap_of(input longint unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
endfunction

// month is 1-based here
function automatic int unsigned month_days(input longint unsigned yr, input int unsigned mon);
    case (mon)
        2:             return leap_of(yr) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
    endcase
endfunction

function automatic longint unsigned epoch_of(input int unsigned yr, input int unsigned mon,
                                             input int unsigned mday, input int unsigned sod);
    longint unsigned days;
    days = 0;
    for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
        days += leap_of(y) ? 366 : 365;
    end
    for (int unsigned m = 1; m < mon; m++) begin
        days += month_days(yr, m);
    end
    days += mday - 1;
    return days * SECS_IN_DAY + sod;
endfunction

class calendar_scoreboard;
    t_pending_date expected_dates[$];
    int unsigned   mismatches;

    function new();
        mismatches = 0;
    endfunction

    function t_cal_date to_calendar(input logic [31:0] secs);
        t_cal_date       r;
        longint unsigned t;
        longint unsigned days;
        longint unsigned rem;
        longint unsigned yr;
        longint unsigned ylen;
        int unsigned     mon;
        int unsigned     mlen;
        t    = 64'(secs) & ((64'd1 << ectc_pkg::TIME_WIDTH) - 1);
        days = t / SECS_IN_DAY;
        rem  = t % SECS_IN_DAY;
        yr   = EPOCH_YEAR;
        while (1) begin
            ylen = leap_of(yr) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            yr++;
        end
        // december takes whatever is left
        mon = 1;
        while (mon < 12) begin
            mlen = month_days(yr, mon);
            if (days < mlen) break;
            days -= mlen;
            mon++;
        end
        r.year   = ectc_pkg::YEAR_W'(yr);
        r.month  = 4'(mon);
        r.day    = 5'(days + 1);
        r.hour   = 5'(rem / SECS_IN_HOUR);
        r.minute = 6'((rem % SECS_IN_HOUR) / SECS_IN_MIN);
        r.second = 6'(rem % SECS_IN_MIN);
        return r;
    endfunction

    function string date_str(input t_cal_date d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d", d.year, d.month, d.day, d.hour,
                         d.minute, d.second);
    endfunction

    function void note_request(input logic [31:0] secs);
        t_pending_date p;
        p.secs = secs;
        p.date = to_calendar(secs);
        expected_dates.push_back(p);
    endfunction

    function void check_result(input t_cal_date got);
        t_pending_date want;
        if (expected_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %s", date_str(got));
            return;
        end
        want = expected_dates.pop_front();
        if (got.year != want.date.year || got.month != want.date.month ||
            got.day != want.date.day || got.hour != want.date.hour ||
            got.minute != want.date.minute || got.second != want.date.second) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch for %0d s: expected %s got %s", want.secs,
                         date_str(want.date), date_str(got));
        end
    endfunction

    function int unsigned pending();
        return expected_dates.size();
    endfunction
endclass

module tb;
    import ectc_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1800;
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned DRAIN_CYCLES   = 250;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef enum int unsigned {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } t_rx_mode;

    typedef enum int unsigned {
        PICK_RAW,
        PICK_DATE,
        PICK_NEW_YEAR
    } t_pick_kind;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [31:0]       i_epoch_seconds;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [YEAR_W-1:0] o_year;
    logic [3:0]        o_month;
    logic [4:0]        o_day;
    logic [4:0]        o_hour;
    logic [5:0]        o_minute;
    logic [5:0]        o_second;

    calendar_scoreboard sb;
    int unsigned        accepted_cnt = 0;
    int unsigned        burst_left = 0;
    int unsigned        idle_cycles = 0;

    epoch_seconds_to_calendar_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    always #5 i_clk = ~i_clk;

    // offer one request, opening a random gap first when the current burst is used up
    task automatic push_seconds(input logic [31:0] secs);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_epoch_seconds <= secs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(secs);
        accepted_cnt++;
    endtask

    function automatic logic [31:0] pick_seconds();
        t_pick_kind  kind;
        int unsigned yr;
        int unsigned mon;
        int unsigned mday;
        int unsigned sod;
        int unsigned last;
        kind = t_pick_kind'($urandom_range(0, 2));
        yr   = $urandom_range(EPOCH_YEAR, 2105);
        case (kind)
            PICK_RAW:
                return $urandom();
            PICK_DATE: begin
                mon  = $urandom_range(1, 12);
                last = month_days(yr, mon);
                case ($urandom_range(0, 2))
                    0:       mday = 1;
                    1:       mday = last;
                    default: mday = $urandom_range(1, last);
                endcase
                case ($urandom_range(0, 2))
                    0:       sod = 0;
                    1:       sod = SECS_IN_DAY - 1;
                    default: sod = $urandom_range(0, SECS_IN_DAY - 1);
                endcase
                return 32'(epoch_of(yr, mon, mday, sod));
            end
            default:
                // straddle midnight of new year; wraps to the top of the range at the epoch
                return 32'(epoch_of(yr, 1, 1, 0) + $urandom_range(0, 3) - 2);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        sb = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_epoch_seconds <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(32'd0);
        directed.push_back(32'hFFFF_FFFF);
        directed.push_back(32'(SECS_IN_DAY - 1));
        directed.push_back(32'(SECS_IN_DAY));
        directed.push_back(32'(epoch_of(1970, 1, 31, 86399)));
        directed.push_back(32'(epoch_of(1972, 2, 29, 0)));
        directed.push_back(32'(epoch_of(1972, 12, 31, 86399)));
        directed.push_back(32'(epoch_of(1999, 12, 31, 86399)));
        directed.push_back(32'(epoch_of(2000, 1, 1, 0)));
        directed.push_back(32'(epoch_of(2000, 2, 29, 43200)));
        directed.push_back(32'(epoch_of(2000, 3, 1, 0)));
        directed.push_back(32'(epoch_of(2100, 2, 28, 86399)));
        directed.push_back(32'(epoch_of(2100, 3, 1, 0)));
        directed.push_back(32'(epoch_of(2105, 12, 31, 86399)));
        directed.push_back(32'(epoch_of(2106, 2, 7, 0)));
        directed.push_back(32'h7FFF_FFFF);
        directed.push_back(32'h8000_0000);
        directed.push_back(32'hAAAA_AAAA);
        directed.push_back(32'h5555_5555);
        foreach (directed[k]) push_seconds(directed[k]);

        repeat (RANDOM_ITEMS) push_seconds(pick_seconds());
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // result side: random stall patterns plus one long hold-off so the core backs up
    initial begin
        t_rx_mode    mode;
        int unsigned span;
        bit          held_off;
        held_off = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && accepted_cnt >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(10, 200);
            repeat (span) begin
                case (mode)
                    RX_OPEN:  i_out_ready <= 1'b1;
                    RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:  i_out_ready <= 1'($urandom_range(0, 1));
                    default:  i_out_ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid && i_out_ready)
            sb.check_result(t_cal_date'{o_year, o_month, o_day, o_hour, o_minute, o_second});
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
